// ===== sv/srf_pkg.sv =====
// Package with the constants, types and codes shared by the substring removal filter.
package srf_pkg;

    // Sizing of the pattern, the held window and the configuration port.
    localparam int PATTERN_MAX = 16;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_REG_W   = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    typedef logic [BYTE_W-1:0] t_byte;

    // One input item: a text byte and its end-of-text flag.
    typedef struct packed {
        t_byte text_byte;
        logic  text_end;
    } t_item;

    // One result item.
    typedef struct packed {
        t_byte kept_byte;
        logic  byte_valid;
        logic  run_last;
    } t_result;

    // Pattern as seen by the core: clamped length and the pattern bytes.
    typedef struct packed {
        logic [CNT_W-1:0]             len;
        t_byte [PATTERN_MAX-1:0]      bytes;
    } t_pattern;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH     = CFG_INDEX_W'(0),
        CFG_PATTERN_BYTES_LOW  = CFG_INDEX_W'(1),
        CFG_PATTERN_BYTES_HIGH = CFG_INDEX_W'(2)
    } t_cfg_index;

    // Core operating mode.
    typedef enum logic {
        MODE_STREAM,
        MODE_FLUSH
    } t_mode;

endpackage

// ===== sv/srf_if.sv =====
// Channel interfaces for the text input, the result output and the configuration port.
interface srf_in_if;
    logic               valid;
    logic               ready;
    srf_pkg::t_byte     text_byte;
    logic               text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface srf_out_if;
    logic               valid;
    logic               ready;
    srf_pkg::t_byte     kept_byte;
    logic               byte_valid;
    logic               run_last;

    modport source (output valid, output kept_byte, output byte_valid, output run_last,
                    input ready);
    modport sink   (input valid, input kept_byte, input byte_valid, input run_last,
                    output ready);
endinterface

interface srf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [srf_pkg::CFG_INDEX_W-1:0]      index;
    logic [srf_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/srf_cfg.sv =====
// Configuration registers of the substring removal filter and the pattern view they feed.
module srf_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    srf_cfg_if.sink             i_cfg,
    output srf_pkg::t_pattern   o_pattern
);

    logic [srf_pkg::LEN_REG_W-1:0]    r_pat_len;
    logic [srf_pkg::CFG_DATA_W-1:0]   r_pat_lo;
    logic [srf_pkg::CFG_DATA_W-1:0]   r_pat_hi;
    logic [2*srf_pkg::CFG_DATA_W-1:0] pat_all;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Register write decoder; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
        end else if (i_cfg.valid) begin
            unique case (srf_pkg::t_cfg_index'(i_cfg.index))
                srf_pkg::CFG_PATTERN_LENGTH:     r_pat_len <= i_cfg.data[srf_pkg::LEN_REG_W-1:0];
                srf_pkg::CFG_PATTERN_BYTES_LOW:  r_pat_lo  <= i_cfg.data;
                srf_pkg::CFG_PATTERN_BYTES_HIGH: r_pat_hi  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A length above the maximum is used as the maximum.
    assign pat_all = {r_pat_hi, r_pat_lo};

    always_comb begin
        if (r_pat_len > srf_pkg::LEN_REG_W'(srf_pkg::PATTERN_MAX)) begin
            o_pattern.len = srf_pkg::CNT_W'(srf_pkg::PATTERN_MAX);
        end else begin
            o_pattern.len = srf_pkg::CNT_W'(r_pat_len);
        end
        for (int i = 0; i < srf_pkg::PATTERN_MAX; i++) begin
            o_pattern.bytes[i] = pat_all[srf_pkg::BYTE_W*i +: srf_pkg::BYTE_W];
        end
    end

endmodule

// ===== sv/srf_core.sv =====
// Held window, pattern compare and end-of-text flush sequencer of the substring removal filter.
module srf_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srf_pkg::t_pattern   i_pattern,
    input  logic                i_item_valid,
    input  srf_pkg::t_item      i_item,
    input  logic                i_out_free,
    output logic                o_item_take,
    output logic                o_res_valid,
    output srf_pkg::t_result    o_res
);

    srf_pkg::t_mode                            r_mode, n_mode;
    logic [srf_pkg::CNT_W-1:0]                 r_count, n_count;
    srf_pkg::t_byte [srf_pkg::PATTERN_MAX-1:0] r_window, n_window;

    logic [srf_pkg::CNT_W-1:0]       seq_len;
    logic [srf_pkg::IDX_W-1:0]       tail_idx;
    logic [srf_pkg::IDX_W-1:0]       last_idx;
    logic [srf_pkg::PATTERN_MAX-1:0] lane_ok;
    srf_pkg::t_byte                  lane_byte;
    srf_pkg::t_byte                  seq_head;
    logic                            match;

    // Held bytes plus the new byte form the candidate sequence.
    assign seq_len  = r_count + srf_pkg::CNT_W'(1);
    assign tail_idx = r_count[srf_pkg::IDX_W-1:0];
    assign last_idx = tail_idx - srf_pkg::IDX_W'(1);
    assign seq_head = (r_count == '0) ? i_item.text_byte : r_window[0];

    // One compare per pattern position; positions past the sequence do not count.
    always_comb begin
        lane_byte = '0;
        for (int i = 0; i < srf_pkg::PATTERN_MAX; i++) begin
            lane_byte  = (srf_pkg::CNT_W'(i) < r_count) ? r_window[i] : i_item.text_byte;
            lane_ok[i] = (srf_pkg::CNT_W'(i) >= seq_len) || (lane_byte == i_pattern.bytes[i]);
        end
    end

    assign match = (i_pattern.len != '0) && (seq_len == i_pattern.len) && (&lane_ok);

    // Mode, window and count update, one result at most per cycle.
    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_window    = r_window;
        o_item_take = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_mode)
            srf_pkg::MODE_STREAM: begin
                if (i_item_valid && i_out_free) begin
                    o_item_take = 1'b1;
                    if (match) begin
                        n_count = '0;
                    end else if (seq_len >= i_pattern.len) begin
                        // Emit the oldest byte and slide the new one in behind the rest.
                        o_res_valid      = 1'b1;
                        o_res.kept_byte  = seq_head;
                        o_res.byte_valid = 1'b1;
                        for (int i = 0; i < srf_pkg::PATTERN_MAX - 1; i++) begin
                            n_window[i] = r_window[i+1];
                        end
                        if (r_count != '0) begin
                            n_window[last_idx] = i_item.text_byte;
                        end
                    end else begin
                        n_window[tail_idx] = i_item.text_byte;
                        n_count            = seq_len;
                    end
                    if (i_item.text_end) begin
                        n_mode = srf_pkg::MODE_FLUSH;
                    end
                end
            end
            srf_pkg::MODE_FLUSH: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    if (r_count != '0) begin
                        // Drain the held bytes oldest first.
                        o_res.kept_byte  = r_window[0];
                        o_res.byte_valid = 1'b1;
                        for (int i = 0; i < srf_pkg::PATTERN_MAX - 1; i++) begin
                            n_window[i] = r_window[i+1];
                        end
                        n_count = r_count - srf_pkg::CNT_W'(1);
                    end else begin
                        // Bare end marker closes the text.
                        o_res.run_last = 1'b1;
                        n_mode         = srf_pkg::MODE_STREAM;
                    end
                end
            end
            default: begin
                n_mode = srf_pkg::MODE_STREAM;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= srf_pkg::MODE_STREAM;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Held bytes carry no reset.
    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    // The held count stays below the window depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < srf_pkg::CNT_W'(srf_pkg::PATTERN_MAX))
        else $error("held count reached the window depth");

    // The held count grows by at most one byte per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count <= $past(r_count) + srf_pkg::CNT_W'(1)))
        else $error("held count grew by more than one");

    // After the end marker the window is empty and streaming resumes.
    a_marker_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.run_last) |=>
            (r_count == '0) && (r_mode == srf_pkg::MODE_STREAM))
        else $error("window not empty after end marker");

    // No item is taken while a flush is in progress.
    a_no_take_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == srf_pkg::MODE_FLUSH) |-> !o_item_take)
        else $error("item taken during flush");

endmodule

// ===== sv/substring_removal_filter.sv =====
// Substring removal filter: drops every leftmost, non-overlapping pattern match from a text.
// The filter takes one text byte per cycle while the result register is free and, while text
// streams, delivers results at the same rate; an accepted byte passes the input register and
// the core on its way to the result register. A byte that may still start a match is held back,
// up to one byte less than the pattern length. After the byte that ends a text the core drains
// each held byte and then the end marker, taking no new byte meanwhile, and at most one more
// waits in the input register; the single result register gives one result per cycle when free.
// The pattern is 0 to 16 bytes long (zero passes every byte through); the user must write it
// through the configuration port only while the filter is idle; the block does not enforce it.
module substring_removal_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srf_cfg_if.sink     i_cfg,
    srf_in_if.sink      i_in,
    srf_out_if.source   o_out
);

    srf_pkg::t_pattern pattern;
    srf_pkg::t_item    r_in_item;
    logic              r_in_valid;
    srf_pkg::t_result  r_out;
    logic              r_out_valid;
    srf_pkg::t_result  core_res;
    logic              core_res_valid;
    logic              core_take;
    logic              out_free;

    srf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_pattern (pattern)
    );

    // Input register: refills in the cycle the core takes its item.
    assign i_in.ready = !r_in_valid || core_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.text_byte <= i_in.text_byte;
            r_in_item.text_end  <= i_in.text_end;
        end
    end

    srf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pattern    (pattern),
        .i_item_valid (r_in_valid),
        .i_item       (r_in_item),
        .i_out_free   (out_free),
        .o_item_take  (core_take),
        .o_res_valid  (core_res_valid),
        .o_res        (core_res)
    );

    // Result register: free when empty or when its transaction completes.
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && core_res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kept_byte  = r_out.kept_byte;
    assign o_out.byte_valid = r_out.byte_valid;
    assign o_out.run_last   = r_out.run_last;

endmodule
